// ===== design/lru_key_value_cache_assert.svh =====
// ----------------------------------------------------------------------------
// LRU key/value cache assertion macros
// Shorthand for clocked implication checks, sampled on clk, off during rst.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication.
`define LKVC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LKVC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Request codes, default sizes and the lookup status word.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int KEY_BYTES_MAX_DEF = 8;

  // Slot index fields in the status word are sized for the largest table.
  localparam int SLOT_IDX_MAX_W = 8;

  localparam logic [4:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    REQ_PUT    = 2'd0,
    REQ_GET    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef struct packed {
    logic                      hit;
    logic [SLOT_IDX_MAX_W-1:0] hit_idx;
    logic [SLOT_IDX_MAX_W-1:0] old_idx;
    logic [SLOT_IDX_MAX_W-1:0] free_idx;        // first empty slot
    logic [SLOT_IDX_MAX_W-1:0] free_evict_idx;  // first empty slot once oldest goes
  } match_t;

endpackage

// ===== design/lkvc_match.sv =====
// ----------------------------------------------------------------------------
// LRU key/value cache slot match
// Parallel key compare over all slots, plus oldest and free slot encoders.
// ----------------------------------------------------------------------------
module lkvc_match #(
  parameter int TABLE_ENTRIES = lkvc_pkg::TABLE_ENTRIES_DEF,
  parameter int KEY_BYTES_MAX = lkvc_pkg::KEY_BYTES_MAX_DEF
) (
  input  logic [8*KEY_BYTES_MAX-1:0]         key,
  input  logic [3:0]                         len,
  input  logic [8*KEY_BYTES_MAX-1:0]         slot_key [TABLE_ENTRIES],
  input  logic [3:0]                         slot_len [TABLE_ENTRIES],
  input  logic [TABLE_ENTRIES-1:0]           slot_valid,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]   slot_rank [TABLE_ENTRIES],
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0] count,
  output lkvc_pkg::match_t                   match
);
  import lkvc_pkg::*;

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [CNT_W-1:0] oldest_rank;

  assign oldest_rank = count - CNT_W'(1);

  // Scan from the top so the lowest matching index wins.
  always_comb begin
    match = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_len[i] == len && slot_key[i] == key) begin
        match.hit     = 1'b1;
        match.hit_idx = SLOT_IDX_MAX_W'(i);
      end
      if (slot_valid[i] && CNT_W'(slot_rank[i]) == oldest_rank) begin
        match.old_idx = SLOT_IDX_MAX_W'(i);
      end
      if (!slot_valid[i]) begin
        match.free_idx = SLOT_IDX_MAX_W'(i);
      end
      if (!slot_valid[i] || CNT_W'(slot_rank[i]) == oldest_rank) begin
        match.free_evict_idx = SLOT_IDX_MAX_W'(i);
      end
    end
  end

endmodule

// ===== design/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative key to value table with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Takes one request word per cycle (put, get, remove, clear) while the result
// register is empty or out_ready is high, and returns one result word per
// request, in order. A request is resolved while it is in the input register:
// every slot compares its key and length in parallel, and the recency ranks,
// valid bits, count, written slot and result register all load at the edge on
// which it leaves. A request passes through the input register and then the
// result register. The rate is set by the single compare-and-update pass
// across all slots. The result register lets a new request enter while a
// finished result waits for out_ready. Ranks run from 0 (most recent) to
// count-1 (oldest), so the eviction victim is the slot whose rank equals
// count-1. Key and value storage is not cleared at reset; of the table state,
// only valid bits, ranks and the count are. capacity_limit must be written
// through the cfg channel only while the block is idle; the block itself does
// not enforce this. Zero disables eviction and a new-key put into a full table
// comes back rejected.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int TABLE_ENTRIES = lkvc_pkg::TABLE_ENTRIES_DEF,
  parameter int KEY_BYTES_MAX = lkvc_pkg::KEY_BYTES_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // config write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [4:0]                         capacity_limit,
  // request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         req_type,
  input  logic [63:0]                        key_bytes,
  input  logic [3:0]                         key_length,
  input  logic [63:0]                        put_value,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               found,
  output logic [63:0]                        value_out,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0] entry_count,
  output logic                               evicted,
  output logic                               rejected
);
  import lkvc_pkg::*;

`include "lru_key_value_cache_assert.svh"

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_W = 8 * KEY_BYTES_MAX;

  // config
  logic [4:0]       cap_reg;
  logic [CNT_W-1:0] cap;

  // input register
  logic             s1_valid;
  req_t             s1_req;
  logic [KEY_W-1:0] s1_key;
  logic [3:0]       s1_len;
  logic [63:0]      s1_val;
  logic [KEY_W-1:0] in_key_m;
  logic             adv;

  // table state
  logic [KEY_W-1:0]         slot_key   [TABLE_ENTRIES];
  logic [3:0]               slot_len   [TABLE_ENTRIES];
  logic [63:0]              slot_value [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] slot_valid;
  logic [IDX_W-1:0]         slot_rank  [TABLE_ENTRIES];
  logic [CNT_W-1:0]         count;

  logic [TABLE_ENTRIES-1:0] slot_valid_next;
  logic [IDX_W-1:0]         slot_rank_next [TABLE_ENTRIES];
  logic [CNT_W-1:0]         count_next;

  // slot writes
  logic             wr_kv;
  logic             wr_v;
  logic [IDX_W-1:0] wr_idx;

  // lookup
  match_t           m;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] old_idx;
  logic [IDX_W-1:0] hit_rank;
  logic             do_evict;
  logic             do_reject;

  // result next values
  logic        res_found;
  logic [63:0] res_value;
  logic        res_evicted;
  logic        res_rejected;

  assign cfg_ready = 1'b1;

  // Capacity above the table size acts as the table size.
  always_comb begin
    if (32'(cap_reg) > 32'(TABLE_ENTRIES)) begin
      cap = CNT_W'(TABLE_ENTRIES);
    end else begin
      cap = CNT_W'(cap_reg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_reg <= capacity_limit;
    end
  end

  // Only the first KEY_BYTES_MAX bytes are kept; bytes at or past the length
  // are zeroed. The full 4-bit length still takes part in the match.
  always_comb begin
    for (int b = 0; b < KEY_BYTES_MAX; b++) begin
      in_key_m[8*b +: 8] = (b < int'(key_length)) ? key_bytes[8*b +: 8] : 8'h00;
    end
  end

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req <= req_t'(req_type);
      s1_key <= in_key_m;
      s1_len <= key_length;
      s1_val <= put_value;
    end
  end

  lkvc_match #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BYTES_MAX (KEY_BYTES_MAX)
  ) u_match (
    .key        (s1_key),
    .len        (s1_len),
    .slot_key   (slot_key),
    .slot_len   (slot_len),
    .slot_valid (slot_valid),
    .slot_rank  (slot_rank),
    .count      (count),
    .match      (m)
  );

  assign hit_idx  = m.hit_idx[IDX_W-1:0];
  assign old_idx  = m.old_idx[IDX_W-1:0];
  assign hit_rank = slot_rank[hit_idx];

  // A new key evicts when a nonzero capacity is reached; with capacity zero
  // only a completely full table turns it away.
  assign do_evict  = (cap != '0) && (count >= cap);
  assign do_reject = (cap == '0) && (count >= CNT_W'(TABLE_ENTRIES));

  always_comb begin
    slot_valid_next = slot_valid;
    slot_rank_next  = slot_rank;
    count_next      = count;
    wr_kv           = 1'b0;
    wr_v            = 1'b0;
    wr_idx          = hit_idx;
    res_found       = 1'b0;
    res_value       = '0;
    res_evicted     = 1'b0;
    res_rejected    = 1'b0;

    unique case (s1_req)
      REQ_PUT: begin
        if (m.hit) begin
          // replace in place, make most recent
          res_found = 1'b1;
          wr_v      = 1'b1;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_valid[i] && slot_rank[i] < hit_rank) begin
              slot_rank_next[i] = slot_rank[i] + IDX_W'(1);
            end
          end
          slot_rank_next[hit_idx] = '0;
        end else if (do_reject) begin
          res_rejected = 1'b1;
        end else begin
          // age everyone left, drop the oldest if evicting, insert at rank 0
          wr_idx = do_evict ? m.free_evict_idx[IDX_W-1:0] : m.free_idx[IDX_W-1:0];
          wr_kv  = 1'b1;
          wr_v   = 1'b1;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_valid[i] && !(do_evict && IDX_W'(i) == old_idx)) begin
              slot_rank_next[i] = slot_rank[i] + IDX_W'(1);
            end
          end
          if (do_evict) begin
            res_evicted              = 1'b1;
            slot_valid_next[old_idx] = 1'b0;
            slot_rank_next[old_idx]  = '0;
          end else begin
            count_next = count + CNT_W'(1);
          end
          slot_valid_next[wr_idx] = 1'b1;
          slot_rank_next[wr_idx]  = '0;
        end
      end
      REQ_GET: begin
        if (m.hit) begin
          res_found = 1'b1;
          res_value = slot_value[hit_idx];
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_valid[i] && slot_rank[i] < hit_rank) begin
              slot_rank_next[i] = slot_rank[i] + IDX_W'(1);
            end
          end
          slot_rank_next[hit_idx] = '0;
        end
      end
      REQ_REMOVE: begin
        if (m.hit) begin
          res_found = 1'b1;
          res_value = slot_value[hit_idx];
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_valid[i] && slot_rank[i] > hit_rank) begin
              slot_rank_next[i] = slot_rank[i] - IDX_W'(1);
            end
          end
          slot_valid_next[hit_idx] = 1'b0;
          slot_rank_next[hit_idx]  = '0;
          count_next               = count - CNT_W'(1);
        end
      end
      REQ_CLEAR: begin
        slot_valid_next = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          slot_rank_next[i] = '0;
        end
        count_next = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      count      <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        slot_rank[i] <= '0;
      end
    end else if (adv) begin
      slot_valid <= slot_valid_next;
      count      <= count_next;
      slot_rank  <= slot_rank_next;
    end
  end

  // key and value storage, no reset
  always_ff @(posedge clk) begin
    if (adv && wr_kv) begin
      slot_key[wr_idx] <= s1_key;
      slot_len[wr_idx] <= s1_len;
    end
    if (adv && wr_v) begin
      slot_value[wr_idx] <= s1_val;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      found       <= res_found;
      value_out   <= res_value;
      entry_count <= count_next;
      evicted     <= res_evicted;
      rejected    <= res_rejected;
    end
  end

  `LKVC_ASSERT_IMP(a_count_matches_valid, 1'b1,
    $countones(slot_valid) == int'(count), "entry count differs from valid slots")
  `LKVC_ASSERT_IMP(a_evict_reject_excl, out_valid,
    !(evicted && rejected), "put both evicted and rejected")
  `LKVC_ASSERT_IMP(a_reject_when_full, out_valid && rejected,
    entry_count == CNT_W'(TABLE_ENTRIES), "put rejected with room in the table")
  `LKVC_ASSERT_IMP(a_found_no_side, out_valid && found,
    !evicted && !rejected, "hit reported with eviction or rejection")
  `LKVC_ASSERT_NXT(a_adv_loads_result, adv,
    out_valid, "resolved request left no result word")

endmodule
